### hw/rtl/value_intern_table_top_macros.svh
// Assertion macros shared by the value intern table checker.
`ifndef VALUE_INTERN_TABLE_TOP_MACROS_SVH
`define VALUE_INTERN_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VIT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define VIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/vit_pkg.sv
// Package with the shared constants, state type and control structs of the intern table.
`timescale 1ns / 1ps

package vit_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_RD_ISSUE,
    ST_RD_CAPTURE,
    ST_DONE
  } vit_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic rd_issue;
    logic set_hit;
    logic set_insert;
    logic set_full;
    logic set_read;
    logic emit;
  } vit_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic hit;
    logic exhausted;
    logic full;
    logic out_free;
  } vit_status_t;

endpackage

### hw/rtl/vit_ctrl.sv
// Controller state machine that sequences lookups, inserts and read-backs.
`timescale 1ns / 1ps

module vit_ctrl
  import vit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  vit_status_t status,
  output vit_cmd_t    cmd,
  output logic        busy
);

  vit_state_t state_r;
  vit_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_nxt = status.mode ? ST_RD_ISSUE : ST_SCAN;
      end
      ST_SCAN: begin
        if (status.hit || status.exhausted) state_nxt = ST_DONE;
      end
      ST_RD_ISSUE: begin
        state_nxt = ST_RD_CAPTURE;
      end
      ST_RD_CAPTURE: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output decode.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan       = 1'b1;
        cmd.set_hit    = status.hit;
        cmd.set_insert = !status.hit && status.exhausted && !status.full;
        cmd.set_full   = !status.hit && status.exhausted && status.full;
      end
      ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
      end
      ST_RD_CAPTURE: begin
        cmd.set_read = 1'b1;
      end
      ST_DONE: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hw/rtl/vit_dp.sv
// Datapath with the entry memory, count, scan pointer and result registers.
`timescale 1ns / 1ps

module vit_dp
  import vit_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  vit_cmd_t               cmd,
  output vit_status_t            status,
  input  logic                   in_mode,
  input  logic [VALUE_WIDTH-1:0] in_lookup_value,
  input  logic [IDX_W-1:0]       in_read_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [IDX_W-1:0]       out_entry_index,
  output logic [VALUE_WIDTH-1:0] out_entry_value,
  output logic [CNT_W-1:0]       out_entry_count,
  output logic                   out_is_new,
  output logic                   out_table_full,
  output logic                   out_out_of_range
);

  // Entry memory: one write port, one registered read port.
  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;

  // Captured request.
  logic                   mode_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [IDX_W-1:0]       read_idx_r;

  // Count and scan state.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] issue_idx_r, issue_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r;

  // Pending result.
  logic [IDX_W-1:0]       res_index_r;
  logic [VALUE_WIDTH-1:0] res_value_r;
  logic [CNT_W-1:0]       res_count_r;
  logic                   res_new_r;
  logic                   res_full_r;
  logic                   res_oor_r;

  // Output register.
  logic out_valid_r;

  logic             issue_ok;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic             we;
  logic             table_is_full;
  logic             read_oor;

  assign table_is_full = (count_r == CNT_W'(TABLE_DEPTH));
  assign issue_ok      = (issue_idx_r < count_r);
  assign read_oor      = !({1'b0, read_idx_r} < count_r);
  assign re            = (cmd.scan && issue_ok) || cmd.rd_issue;
  assign raddr         = cmd.scan ? issue_idx_r[IDX_W-1:0] : read_idx_r;
  assign we            = cmd.set_insert;

  // Memory access.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[count_r[IDX_W-1:0]] <= value_r;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  // Scan pointer and in-flight read tracking.
  always_comb begin
    issue_idx_nxt = issue_idx_r;
    rd_vld_nxt    = 1'b0;
    if (cmd.load) begin
      issue_idx_nxt = '0;
    end else if (cmd.scan && issue_ok) begin
      issue_idx_nxt = issue_idx_r + 1'b1;
      rd_vld_nxt    = 1'b1;
    end
  end

  assign count_nxt = cmd.set_insert ? count_r + 1'b1 : count_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      issue_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      issue_idx_r <= issue_idx_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture and the index of the read in flight.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= in_mode;
      value_r    <= in_lookup_value;
      read_idx_r <= in_read_index;
    end
    if (re) begin
      rd_idx_r <= raddr;
    end
  end

  // Result formation for each way an item can end.
  always_ff @(posedge clk) begin
    if (cmd.set_hit || cmd.set_insert || cmd.set_full || cmd.set_read) begin
      res_index_r <= '0;
      res_value_r <= '0;
      res_count_r <= count_nxt;
      res_new_r   <= 1'b0;
      res_full_r  <= 1'b0;
      res_oor_r   <= 1'b0;
      if (cmd.set_hit) begin
        res_index_r <= rd_idx_r;
      end else if (cmd.set_insert) begin
        res_index_r <= count_r[IDX_W-1:0];
        res_new_r   <= 1'b1;
      end else if (cmd.set_full) begin
        res_full_r  <= 1'b1;
      end else begin
        res_value_r <= read_oor ? '0 : rd_data_r;
        res_oor_r   <= read_oor;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_entry_index  <= res_index_r;
      out_entry_value  <= res_value_r;
      out_entry_count  <= res_count_r;
      out_is_new       <= res_new_r;
      out_table_full   <= res_full_r;
      out_out_of_range <= res_oor_r;
    end
  end

  assign out_valid = out_valid_r;

  // Status to the controller.
  assign status.mode      = mode_r;
  assign status.hit       = rd_vld_r && (rd_data_r == value_r);
  assign status.exhausted = !rd_vld_r && !issue_ok;
  assign status.full      = table_is_full;
  assign status.out_free  = !out_valid_r || !out_stall;

endmodule

### hw/rtl/value_intern_table_top.sv
// Top level of the value intern table: controller plus datapath.
`timescale 1ns / 1ps

// A find-or-insert table of up to 256 distinct 32-bit values. Mode 0 looks a
// value up and returns the index of its first occurrence, or appends it and
// flags it as new, or flags the table as full when there is no room. Mode 1
// reads back the entry at an index and flags indices not below the count.
// Every result carries the entry count after the request. One request is in
// work at a time, paced by the single read port of the entry memory, which the
// scan walks one entry per cycle. A finished result waits in the output
// register while the next request is accepted; the input opens again in the
// cycle after the result is loaded there.

module value_intern_table_top
  import vit_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  logic [VALUE_WIDTH-1:0] in_lookup_value,
  input  logic [IDX_W-1:0]       in_read_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [IDX_W-1:0]       out_entry_index,
  output logic [VALUE_WIDTH-1:0] out_entry_value,
  output logic [CNT_W-1:0]       out_entry_count,
  output logic                   out_is_new,
  output logic                   out_table_full,
  output logic                   out_out_of_range
);

  vit_cmd_t    cmd;
  vit_status_t status;
  logic        busy;

  assign in_stall = busy;

  // Sequencer.
  vit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Storage and result path.
  vit_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_mode          (in_mode),
    .in_lookup_value  (in_lookup_value),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_entry_index  (out_entry_index),
    .out_entry_value  (out_entry_value),
    .out_entry_count  (out_entry_count),
    .out_is_new       (out_is_new),
    .out_table_full   (out_table_full),
    .out_out_of_range (out_out_of_range)
  );

endmodule

### hw/rtl/vit_checker.sv
// Port-level assertion checker for the value intern table, bound to the top level.
`timescale 1ns / 1ps
`include "value_intern_table_top_macros.svh"

module vit_checker
  import vit_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [IDX_W-1:0]       out_entry_index,
  input logic [CNT_W-1:0]       out_entry_count,
  input logic                   out_is_new,
  input logic                   out_table_full,
  input logic                   out_out_of_range
);

  // A stalled result stays offered.
  `VIT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

  // Only one request is in work: acceptance closes the input at once.
  `VIT_ASSERT_NEXT(a_one_in_work, in_valid && !in_stall, in_stall, "second request accepted")

  // A new entry is the last one stored.
  `VIT_ASSERT_NOW(a_new_is_last, out_valid && out_is_new,
    out_entry_count == CNT_W'(out_entry_index) + 1'b1, "new index does not match count")

  // A full report comes only from a full table and carries index zero.
  `VIT_ASSERT_NOW(a_full_state, out_valid && out_table_full,
    out_entry_count == CNT_W'(TABLE_DEPTH) && out_entry_index == '0 && !out_is_new,
    "full flag with inconsistent fields")

  // Flags of the two modes never mix.
  `VIT_ASSERT_NOW(a_flags_excl, out_valid && out_out_of_range,
    !out_is_new && !out_table_full, "read flag mixed with lookup flags")

endmodule

bind value_intern_table_top vit_checker u_vit_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_entry_index  (out_entry_index),
  .out_entry_count  (out_entry_count),
  .out_is_new       (out_is_new),
  .out_table_full   (out_table_full),
  .out_out_of_range (out_out_of_range)
);
